// ===== hdl/les_pkg.sv =====
// Shared types and constants for the largest empty square finder.
// No dependencies; every other file in hdl/ refers to this package.
`default_nettype none

package les_pkg;

  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;

  localparam int COL_W  = 10;  // column index
  localparam int ROW_W  = 10;  // row index
  localparam int VAL_W  = 11;  // square side, 0 .. MAX_COLS
  localparam int CHAR_W = 8;
  localparam int CFG_W  = 11;  // widest configuration register
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_CHAR   = 1'b1;

  localparam logic [VAL_W-1:0]  COLUMN_COUNT_RESET = 11'd1024;
  localparam logic [CHAR_W-1:0] EMPTY_CHAR_RESET   = 8'd46;

  localparam logic [VAL_W-1:0] MAX_COLS_V = VAL_W'(MAX_COLS);
  localparam logic [ROW_W-1:0] LAST_ROW   = ROW_W'(MAX_ROWS - 1);

  // Context of the cell under evaluation.
  typedef struct packed {
    logic             is_empty;
    logic             first_row;
    logic             first_col;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } cell_ctx_t;

  // Best square found so far.
  typedef struct packed {
    logic [VAL_W-1:0] size;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } best_t;

endpackage

`default_nettype wire

// ===== hdl/les_line_buf.sv =====
// Line buffer holding the previous row's square sizes, one entry per column.
// Registered read with write-to-read bypass; uses les_pkg.
`default_nettype none

module les_line_buf (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      rd_en,
  input  wire logic [les_pkg::COL_W-1:0] rd_addr,
  input  wire logic                      wr_en,
  input  wire logic [les_pkg::COL_W-1:0] wr_addr,
  input  wire logic [les_pkg::VAL_W-1:0] wr_data,
  output logic      [les_pkg::VAL_W-1:0] rd_data
);

  logic [les_pkg::VAL_W-1:0] mem [les_pkg::MAX_COLS];
  logic [les_pkg::VAL_W-1:0] rd_q;
  logic [les_pkg::VAL_W-1:0] byp_data;
  logic                      byp;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q     <= mem[rd_addr];
      byp_data <= wr_data;
    end
  end

  // A read that hits the entry written in the same cycle takes the new word.
  always_ff @(posedge clk) begin
    if (rst) begin
      byp <= 1'b0;
    end else if (rd_en) begin
      byp <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = byp ? byp_data : rd_q;

endmodule

`default_nettype wire

// ===== hdl/les_cell_calc.sv =====
// Square size of one cell and the update of the best square record.
// Purely combinational; uses les_pkg.
`default_nettype none

module les_cell_calc (
  input  wire les_pkg::cell_ctx_t         ctx,
  input  wire logic [les_pkg::VAL_W-1:0]  up,
  input  wire logic [les_pkg::VAL_W-1:0]  left,
  input  wire logic [les_pkg::VAL_W-1:0]  diag,
  input  wire les_pkg::best_t             best,
  output logic      [les_pkg::VAL_W-1:0]  value,
  output les_pkg::best_t                  best_next
);

  logic [les_pkg::VAL_W-1:0] min_ul;
  logic [les_pkg::VAL_W-1:0] min_all;
  logic [les_pkg::VAL_W-1:0] col_p1;
  logic [les_pkg::VAL_W-1:0] row_p1;
  logic [les_pkg::VAL_W-1:0] col_top;
  logic [les_pkg::VAL_W-1:0] row_top;

  always_comb begin
    min_ul  = (up < left) ? up : left;
    min_all = (min_ul < diag) ? min_ul : diag;
    if (!ctx.is_empty) begin
      value = '0;
    end else if (ctx.first_row || ctx.first_col) begin
      value = les_pkg::VAL_W'(1);
    end else begin
      value = min_all + les_pkg::VAL_W'(1);
    end
  end

  // The top-left row clamps to 0 when the square reaches above the map,
  // which only happens once the row counter has saturated.
  always_comb begin
    col_p1  = {1'b0, ctx.col} + les_pkg::VAL_W'(1);
    row_p1  = {1'b0, ctx.row} + les_pkg::VAL_W'(1);
    col_top = col_p1 - value;
    row_top = (value > row_p1) ? '0 : row_p1 - value;
    best_next = best;
    if (value > best.size) begin
      best_next.size = value;
      best_next.col  = col_top[les_pkg::COL_W-1:0];
      best_next.row  = row_top[les_pkg::ROW_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/largest_empty_square_finder.sv =====
// Top level of the largest empty square finder: stream ports, configuration
// registers, position counters and the cell stage. Uses les_pkg,
// les_line_buf and les_cell_calc.
//
//  Port group   Dir  Payload (low bit first)             Note
//  s_axis_*     in   tdata: cell_char[7:0]; tlast       one map cell
//  m_axis_*     out  tdata: square_size, square_col,     one word per map
//                    square_row, zero pad to 32 bits
//  cfg_*        in   cfg_index selects, cfg_data         write only
//
// One cell per cycle unless a last cell waits for the output register. A
// cell is registered on acceptance while its upper neighbor is read from
// the line buffer; the stage then computes its size and writes it back as
// the cell leaves, and the result word is registered as the last cell leaves.
// A stalled output only blocks the stage once another last cell reaches it.
// Synchronous reset restores the register defaults but does not clear the buffer.
`default_nettype none

module largest_empty_square_finder (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [7:0]                    s_axis_tdata,   // cell_char[7:0]
  input  wire logic                          s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // square_size[10:0], square_col[20:11], square_row[30:21], zero[31]
  output logic [31:0]                        m_axis_tdata,
  input  wire logic                          cfg_we,
  input  wire logic [les_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [les_pkg::CFG_W-1:0]     cfg_data
);

  logic [les_pkg::VAL_W-1:0]  column_count;
  logic [les_pkg::CHAR_W-1:0] empty_char;
  logic [les_pkg::VAL_W-1:0]  width;

  logic [les_pkg::COL_W-1:0]  col_index;
  logic [les_pkg::ROW_W-1:0]  row_index;
  logic                       col_wrap;
  logic                       s_acc;

  logic                       s1_valid;
  logic [les_pkg::CHAR_W-1:0] s1_char;
  logic                       s1_last;
  logic                       s1_wrap;
  logic [les_pkg::COL_W-1:0]  s1_col;
  logic [les_pkg::ROW_W-1:0]  s1_row;
  logic                       s1_adv;

  logic [les_pkg::VAL_W-1:0]  left_value;
  logic [les_pkg::VAL_W-1:0]  diag_value;
  logic [les_pkg::VAL_W-1:0]  up_value;
  logic [les_pkg::VAL_W-1:0]  cell_value;
  les_pkg::best_t             best;
  les_pkg::best_t             best_next;
  les_pkg::cell_ctx_t         ctx;

  logic                       out_valid;
  les_pkg::best_t             out_word;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= les_pkg::COLUMN_COUNT_RESET;
      empty_char   <= les_pkg::EMPTY_CHAR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        les_pkg::REG_COLUMN_COUNT: column_count <= cfg_data;
        les_pkg::REG_EMPTY_CHAR:   empty_char   <= cfg_data[les_pkg::CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero width counts as one column; widths above the buffer are clamped.
  always_comb begin
    if (column_count == '0) begin
      width = les_pkg::VAL_W'(1);
    end else if (column_count > les_pkg::MAX_COLS_V) begin
      width = les_pkg::MAX_COLS_V;
    end else begin
      width = column_count;
    end
  end

  assign col_wrap = ({1'b0, col_index} + les_pkg::VAL_W'(1)) >= width;

  // The last cell can only leave the stage when the output register is free.
  assign s1_adv        = s1_valid && (!s1_last || !out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_adv;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  // Position of the next incoming cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_index <= '0;
      row_index <= '0;
    end else if (s_acc) begin
      if (s_axis_tlast) begin
        col_index <= '0;
        row_index <= '0;
      end else if (col_wrap) begin
        col_index <= '0;
        if (row_index != les_pkg::LAST_ROW) begin
          row_index <= row_index + les_pkg::ROW_W'(1);
        end
      end else begin
        col_index <= col_index + les_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      s1_char <= s_axis_tdata;
      s1_last <= s_axis_tlast;
      s1_wrap <= col_wrap;
      s1_col  <= col_index;
      s1_row  <= row_index;
    end
  end

  les_line_buf u_line_buf (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (s_acc),
    .rd_addr (col_index),
    .wr_en   (s1_adv),
    .wr_addr (s1_col),
    .wr_data (cell_value),
    .rd_data (up_value)
  );

  always_comb begin
    ctx.is_empty  = (s1_char == empty_char);
    ctx.first_row = (s1_row == '0);
    ctx.first_col = (s1_col == '0);
    ctx.col       = s1_col;
    ctx.row       = s1_row;
  end

  les_cell_calc u_cell_calc (
    .ctx       (ctx),
    .up        (up_value),
    .left      (left_value),
    .diag      (diag_value),
    .best      (best),
    .value     (cell_value),
    .best_next (best_next)
  );

  // Neighbor and best-square state, committed as the cell leaves the stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_value <= '0;
      diag_value <= '0;
      best       <= '0;
    end else if (s1_adv) begin
      if (s1_last) begin
        left_value <= '0;
        diag_value <= '0;
        best       <= '0;
      end else begin
        best <= best_next;
        if (s1_wrap) begin
          left_value <= '0;
          diag_value <= '0;
        end else begin
          left_value <= cell_value;
          diag_value <= up_value;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_last) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last) begin
      out_word <= best_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_word.row, out_word.col, out_word.size};

  // The map state is cleared once the last cell has been committed.
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_last) |=> (best.size == '0 && left_value == '0 && diag_value == '0))
    else $error("map state not cleared after last cell");

  // A new result only comes from a committed last cell.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s1_adv && s1_last))
    else $error("result word raised without a last cell");

  // A corner is recorded only together with a nonzero size.
  a_best_corner: assert property (@(posedge clk) disable iff (rst)
    (best.size == '0) |-> (best.col == '0 && best.row == '0))
    else $error("corner recorded without a square");

endmodule

`default_nettype wire

// ===== bench/largest_empty_square_finder_tb.sv =====
// Self-checking bench for largest_empty_square_finder: streams maps of cells
// under changing register settings and checks every result word against an
// in-bench prediction. Depends on les_pkg and the block's RTL.
`timescale 1ns / 1ps

module largest_empty_square_finder_tb;

  localparam int CELL_TARGET = 1950;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [les_pkg::CHAR_W-1:0] ch;
    logic                       is_last;
  } cell_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [7:0]                    s_axis_tdata = '0;   // cell_char[7:0]
  logic                          s_axis_tlast = 1'b0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  // square_size[10:0], square_col[20:11], square_row[30:21], zero[31]
  logic [31:0]                   m_axis_tdata;
  logic                          cfg_we = 1'b0;
  logic [les_pkg::CFG_IDX_W-1:0] cfg_index = les_pkg::REG_COLUMN_COUNT;
  logic [les_pkg::CFG_W-1:0]     cfg_data = '0;

  largest_empty_square_finder uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Pending cells and predicted squares.
  cell_t          cells_q[$];
  les_pkg::best_t squares_q[$];

  // Predictor copy of the block's registers and map state.
  logic [les_pkg::VAL_W-1:0]  map_cols  = les_pkg::COLUMN_COUNT_RESET;
  logic [les_pkg::CHAR_W-1:0] map_empty = les_pkg::EMPTY_CHAR_RESET;
  logic [les_pkg::VAL_W-1:0]  line_vals[les_pkg::MAX_COLS];
  logic [les_pkg::VAL_W-1:0]  left_val = '0;
  logic [les_pkg::VAL_W-1:0]  diag_val = '0;
  logic [les_pkg::COL_W-1:0]  cur_col = '0;
  logic [les_pkg::ROW_W-1:0]  cur_row = '0;
  les_pkg::best_t             best = '0;

  int errors = 0;
  int items_sent = 0;
  int maps_sent = 0;
  int settings_used = 1;
  int squares_checked = 0;
  int cycles = 0;

  // Sender pacing; steady is set by the stimulus process.
  int burst_left = 1;
  int gap_left = 0;
  bit steady = 1'b0;

  // Advances the predicted map by one accepted cell.
  task automatic fold_cell(input logic [les_pkg::CHAR_W-1:0] ch, input logic is_last);
    int width;
    int col;
    int up;
    int v;
    width = map_cols;
    if (width == 0) width = 1;
    if (width > les_pkg::MAX_COLS) width = les_pkg::MAX_COLS;
    col = cur_col;
    up = line_vals[col];
    if (ch != map_empty) begin
      v = 0;
    end else if (cur_row == 0 || col == 0) begin
      v = 1;
    end else begin
      v = up;
      if (left_val < v) v = left_val;
      if (diag_val < v) v = diag_val;
      v = v + 1;
    end
    if (v > best.size) begin
      best.size = les_pkg::VAL_W'(v);
      best.col = les_pkg::COL_W'(col + 1 - v);
      // A square taller than the rows seen can only follow row saturation.
      best.row = (v > cur_row + 1) ? '0 : les_pkg::ROW_W'(cur_row + 1 - v);
    end
    line_vals[col] = les_pkg::VAL_W'(v);
    diag_val = les_pkg::VAL_W'(up);
    left_val = les_pkg::VAL_W'(v);
    if (col + 1 >= width) begin
      cur_col = '0;
      left_val = '0;
      diag_val = '0;
      if (cur_row < les_pkg::MAX_ROWS - 1) cur_row = cur_row + 1'b1;
    end else begin
      cur_col = les_pkg::COL_W'(col + 1);
    end
    if (is_last) begin
      squares_q.push_back(best);
      best = '0;
      left_val = '0;
      diag_val = '0;
      cur_col = '0;
      cur_row = '0;
    end
  endtask

  task automatic push_cell(input logic [les_pkg::CHAR_W-1:0] ch, input logic is_last);
    cell_t c;
    c.ch = ch;
    c.is_last = is_last;
    cells_q.push_back(c);
    items_sent++;
    if (is_last) maps_sent++;
  endtask

  // One map of random content: mostly empty cells, some obstacles, a little noise.
  task automatic queue_map(input int cells, input int obstacle_pct, input int noise_pct);
    int pick;
    logic [les_pkg::CHAR_W-1:0] ch;
    for (int k = 0; k < cells; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < noise_pct) begin
        ch = les_pkg::CHAR_W'($urandom_range(0, 255));
      end else if (pick < noise_pct + obstacle_pct) begin
        ch = map_empty + les_pkg::CHAR_W'($urandom_range(1, 255));
      end else begin
        ch = map_empty;
      end
      push_cell(ch, k == cells - 1);
    end
  endtask

  task automatic write_reg(input logic [les_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= les_pkg::CFG_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == les_pkg::REG_COLUMN_COUNT) map_cols = les_pkg::VAL_W'(value);
    else map_empty = les_pkg::CHAR_W'(value);
  endtask

  // Block until every cell is in and every square is out, then let it settle.
  task automatic wait_idle();
    do @(negedge clk);
    while (cells_q.size() != 0 || s_axis_tvalid || squares_q.size() != 0);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  always @(posedge clk) begin : drive_cells
    cell_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) fold_cell(s_axis_tdata, s_axis_tlast);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (cells_q.size() > 0) begin
          nxt = cells_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= nxt.ch;
          s_axis_tlast <= nxt.is_last;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 32);
            gap_left = steady ? 0 : $urandom_range(0, 6);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: modes of full speed, coin-flip readiness and occasional long stalls.
  int sink_mode = 0;
  int sink_mode_left = 0;
  int stall_left = 0;

  always @(posedge clk) begin : drive_sink
    logic rdy;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (sink_mode_left == 0) begin
        sink_mode = $urandom_range(0, 2);
        sink_mode_left = $urandom_range(50, 300);
      end else begin
        sink_mode_left--;
      end
      rdy = 1'b1;
      if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (sink_mode == 1) begin
        rdy = $urandom_range(0, 1);
      end else if (sink_mode == 2 && $urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(1, 20);
        rdy = 1'b0;
      end
      m_axis_tready <= rdy;
    end
  end

  always @(posedge clk) begin : check_squares
    les_pkg::best_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (squares_q.size() == 0) begin
        $error("result word with nothing expected: tdata=%h", m_axis_tdata);
        errors++;
      end else begin
        want = squares_q.pop_front();
        squares_checked++;
        if (m_axis_tdata[10:0] !== want.size) begin
          $error("square_size: expected %0d, got %0d", want.size, m_axis_tdata[10:0]);
          errors++;
        end
        if (m_axis_tdata[20:11] !== want.col) begin
          $error("square_col: expected %0d, got %0d", want.col, m_axis_tdata[20:11]);
          errors++;
        end
        if (m_axis_tdata[30:21] !== want.row) begin
          $error("square_row: expected %0d, got %0d", want.row, m_axis_tdata[30:21]);
          errors++;
        end
        if (m_axis_tdata[31] !== 1'b0) begin
          $error("pad: expected 0, got %b", m_axis_tdata[31]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d cells pending, %0d squares outstanding",
               cycles, cells_q.size(), squares_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int w;
    int eff;
    int cells;
    int rows;
    logic [les_pkg::CHAR_W-1:0] ch;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: one-cell maps, empty and blocked, with the extreme codes.
    push_cell(8'd46, 1'b1);
    push_cell(8'd0, 1'b1);
    push_cell(8'd255, 1'b1);
    push_cell(8'd88, 1'b1);
    wait_idle();

    // Three-wide rows, zero as the empty code.
    write_reg(les_pkg::REG_COLUMN_COUNT, 3);
    write_reg(les_pkg::REG_EMPTY_CHAR, 0);
    settings_used++;
    @(negedge clk);
    for (int k = 0; k < 9; k++) push_cell(8'd0, k == 8);
    push_cell(8'd0, 1'b0);
    push_cell(8'd7, 1'b0);
    push_cell(8'd0, 1'b0);
    push_cell(8'd0, 1'b0);
    push_cell(8'd0, 1'b0);
    push_cell(8'd0, 1'b1);
    wait_idle();

    // A zero width behaves as one column.
    write_reg(les_pkg::REG_COLUMN_COUNT, 0);
    write_reg(les_pkg::REG_EMPTY_CHAR, 255);
    settings_used++;
    @(negedge clk);
    push_cell(8'd255, 1'b0);
    push_cell(8'd255, 1'b0);
    push_cell(8'd255, 1'b1);
    wait_idle();

    // Widest register value clamps to the maximum row length.
    write_reg(les_pkg::REG_COLUMN_COUNT, 2047);
    write_reg(les_pkg::REG_EMPTY_CHAR, $urandom_range(0, 255));
    settings_used++;
    @(negedge clk);
    repeat (4) queue_map($urandom_range(1, 60), $urandom_range(0, 30), 5);
    wait_idle();

    // One column, enough rows to saturate the row counter before the first empty cell.
    write_reg(les_pkg::REG_COLUMN_COUNT, 1);
    write_reg(les_pkg::REG_EMPTY_CHAR, $urandom_range(0, 255));
    settings_used++;
    @(negedge clk);
    for (int k = 0; k < 1030; k++) begin
      ch = (k < 1027) ? map_empty + les_pkg::CHAR_W'($urandom_range(1, 255)) : map_empty;
      push_cell(ch, k == 1029);
    end
    wait_idle();

    while (items_sent < CELL_TARGET) begin
      case ($urandom_range(0, 9))
        6:       w = $urandom_range(25, 64);
        7:       w = les_pkg::MAX_COLS;
        8:       w = $urandom_range(les_pkg::MAX_COLS + 1, 2047);
        9:       w = $urandom_range(0, 1);
        default: w = $urandom_range(2, 24);
      endcase
      write_reg(les_pkg::REG_COLUMN_COUNT, w);
      if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 4))
          0:       write_reg(les_pkg::REG_EMPTY_CHAR, 0);
          1:       write_reg(les_pkg::REG_EMPTY_CHAR, 255);
          default: write_reg(les_pkg::REG_EMPTY_CHAR, $urandom_range(0, 255));
        endcase
      end
      settings_used++;
      steady = ($urandom_range(0, 3) == 0);
      @(negedge clk);
      eff = (w == 0) ? 1 : (w > les_pkg::MAX_COLS ? les_pkg::MAX_COLS : w);
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 9) == 0) begin
          cells = 1;
        end else if (eff > 64) begin
          cells = $urandom_range(1, 60);
        end else begin
          rows = $urandom_range(1, eff <= 16 ? 8 : 3);
          cells = eff * rows;
          // Some maps stop partway through a row.
          if (eff > 1 && rows > 1 && $urandom_range(0, 2) == 0)
            cells = cells - $urandom_range(1, eff - 1);
        end
        queue_map(cells,
                  ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 35),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : 0);
      end
      wait_idle();
    end

    repeat (20) @(posedge clk);
    $display("Sent %0d cells in %0d maps across %0d register settings; %0d squares compared.",
             items_sent, maps_sent, settings_used, squares_checked);
    if (errors == 0 && squares_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/les_pkg.sv
hdl/les_line_buf.sv
hdl/les_cell_calc.sv
hdl/largest_empty_square_finder.sv
bench/largest_empty_square_finder_tb.sv
